>>> hw/rtl/iterative_integer_alu_defines.svh
// Assertion macros for the iterative integer ALU.
// Used by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef ITERATIVE_INTEGER_ALU_DEFINES_SVH
`define ITERATIVE_INTEGER_ALU_DEFINES_SVH

// Plain condition checked every cycle outside reset.
`define IIA_ASSERT_NOW(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) cond) else $error(msg);

// Trigger in one cycle, consequence in the next.
`define IIA_ASSERT_NEXT(name, trig, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) trig |=> cons) else $error(msg);

`endif

>>> hw/rtl/iia_pkg.sv
// Shared types and constants for the iterative integer ALU.
// No dependencies; used by controller, datapath and top level.
package iia_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    localparam logic [CNT_W-1:0]      CNT_LAST = CNT_W'(DATA_WIDTH - 1);
    localparam logic [DATA_WIDTH-1:0] INT_MIN  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] INT_MAX  = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } alu_mode_t;

    typedef struct packed {
        alu_mode_t                     mode;
        logic signed [DATA_WIDTH-1:0]  operand_a;
        logic signed [DATA_WIDTH-1:0]  operand_b;
    } alu_req_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  result;
        logic                          div_by_zero;
    } alu_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIX
    } ctl_state_t;

    typedef struct packed {
        logic load;       // capture a new beat
        logic step;       // one multiply or divide iteration
        logic write_out;  // final fix-up into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic iter_op;    // latched op needs the iteration loop
        logic cnt_last;   // current iteration is the last one
    } dp_status_t;

endpackage

>>> hw/rtl/iterative_integer_alu.sv
// Iterative integer ALU: add, subtract, shift-add multiply and restoring divide.
// Depends on iia_pkg, iia_controller and iia_datapath.
//
// Usage:
//   Request channel (req_valid, req_stall, req) carries mode and two signed
//   32-bit operands; a beat is taken when req_valid is high and req_stall low.
//   Response channel (rsp_valid, rsp_stall, rsp) carries the signed result and
//   the divide-by-zero flag; one response beat per request beat, in order.
//   Sequence: add and subtract go from load through the run state to the
//   fix-up; multiply and divide load, run 32 iterations of the shared
//   shift-add / shift-subtract step, then fix up. The response is
//   valid the cycle after the fix-up. A new request is taken the cycle after
//   the fix-up, so a new request waits until the previous one is through.
//   Divide by zero returns 0 with div_by_zero set; most negative divided by
//   minus one returns the most positive value.
//   A stalled response holds in the output register; the next request is
//   still taken and worked on, and waits in the fix-up state until the output
//   register frees up.
//   Reset (rst_n low, asynchronous) returns to idle and drops rsp_valid.
module iterative_integer_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  iia_pkg::alu_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output iia_pkg::alu_rsp_t rsp
);

    iia_pkg::dp_cmd_t    cmd;
    iia_pkg::dp_status_t status;

    iia_controller u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    iia_datapath u_dp (
        .clk    (clk),
        .req    (req),
        .cmd    (cmd),
        .status (status),
        .rsp    (rsp)
    );

endmodule

>>> hw/rtl/iia_datapath.sv
// Datapath of the iterative integer ALU: operand registers, shift-add
// multiplier, restoring divider and result register. Depends on iia_pkg.
module iia_datapath (
    input  logic                clk,
    input  iia_pkg::alu_req_t   req,
    input  iia_pkg::dp_cmd_t    cmd,
    output iia_pkg::dp_status_t status,
    output iia_pkg::alu_rsp_t   rsp
);

    localparam int W = iia_pkg::DATA_WIDTH;

    iia_pkg::alu_mode_t       mode_reg;
    logic [W-1:0]             a_reg;
    logic [W-1:0]             b_reg;
    logic [W-1:0]             acc_reg, acc_next;
    logic [W-1:0]             mcand_reg, mcand_next;   // multiplicand, or divisor magnitude
    logic [W-1:0]             shf_reg, shf_next;       // multiplier, or dividend/quotient
    logic [W-1:0]             rem_reg, rem_next;
    logic [iia_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                     neg_reg, neg_next;
    iia_pkg::alu_rsp_t        rsp_reg, rsp_next;

    logic [W-1:0] a_in, b_in, a_mag, b_mag;
    logic [W:0]   rem_sh, den_ext, diff;
    logic         ge;
    logic [W-1:0] res_fix;
    logic         dz_fix;

    always_comb
    begin
        a_in  = req.operand_a;
        b_in  = req.operand_b;
        a_mag = a_in[W-1] ? (~a_in + 1'b1) : a_in;
        b_mag = b_in[W-1] ? (~b_in + 1'b1) : b_in;

        rem_sh  = {rem_reg, shf_reg[W-1]};
        den_ext = {1'b0, mcand_reg};
        diff    = rem_sh - den_ext;
        ge      = (rem_sh >= den_ext);

        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        shf_next   = shf_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;

        if (cmd.load)
        begin
            acc_next   = '0;
            rem_next   = '0;
            cnt_next   = '0;
            neg_next   = a_in[W-1] ^ b_in[W-1];
            mcand_next = (req.mode == iia_pkg::MODE_DIV) ? b_mag : a_in;
            shf_next   = (req.mode == iia_pkg::MODE_DIV) ? a_mag : b_in;
        end
        else if (cmd.step)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (mode_reg == iia_pkg::MODE_MUL)
            begin
                acc_next   = acc_reg + (shf_reg[0] ? mcand_reg : '0);
                mcand_next = {mcand_reg[W-2:0], 1'b0};
                shf_next   = {1'b0, shf_reg[W-1:1]};
            end
            else
            begin
                // remainder stays below the divisor, so W bits hold it
                rem_next = ge ? diff[W-1:0] : rem_sh[W-1:0];
                shf_next = {shf_reg[W-2:0], ge};
            end
        end

        dz_fix = 1'b0;
        case (mode_reg)
            iia_pkg::MODE_ADD: res_fix = a_reg + b_reg;
            iia_pkg::MODE_SUB: res_fix = a_reg - b_reg;
            iia_pkg::MODE_MUL: res_fix = acc_reg;
            iia_pkg::MODE_DIV:
            begin
                if (b_reg == '0)
                begin
                    res_fix = '0;
                    dz_fix  = 1'b1;
                end
                else if (a_reg == iia_pkg::INT_MIN && b_reg == '1)
                    res_fix = iia_pkg::INT_MAX;
                else
                    res_fix = neg_reg ? (~shf_reg + 1'b1) : shf_reg;
            end
            default: res_fix = '0;
        endcase

        rsp_next = rsp_reg;
        if (cmd.write_out)
        begin
            rsp_next.result      = res_fix;
            rsp_next.div_by_zero = dz_fix;
        end

        status.iter_op  = (mode_reg == iia_pkg::MODE_MUL) || (mode_reg == iia_pkg::MODE_DIV);
        status.cnt_last = (cnt_reg == iia_pkg::CNT_LAST);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= req.mode;
            a_reg    <= req.operand_a;
            b_reg    <= req.operand_b;
        end
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        shf_reg   <= shf_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        neg_reg   <= neg_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp = rsp_reg;

endmodule

>>> hw/rtl/iia_controller.sv
// Controller of the iterative integer ALU: sequencing FSM and output valid.
// Depends on iia_pkg and iterative_integer_alu_defines.svh.
`include "iterative_integer_alu_defines.svh"

module iia_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    input  iia_pkg::dp_status_t status,
    output iia_pkg::dp_cmd_t    cmd
);

    iia_pkg::ctl_state_t state_reg, state_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic                out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= iia_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        out_free      = !rsp_valid_reg || !rsp_stall;
        state_next    = state_reg;
        cmd.load      = 1'b0;
        cmd.step      = 1'b0;
        cmd.write_out = 1'b0;
        req_stall     = 1'b1;

        case (state_reg)
            iia_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = iia_pkg::ST_RUN;
                end
            end
            iia_pkg::ST_RUN:
            begin
                if (!status.iter_op)
                    state_next = iia_pkg::ST_FIX;
                else
                begin
                    cmd.step = 1'b1;
                    if (status.cnt_last)
                        state_next = iia_pkg::ST_FIX;
                end
            end
            iia_pkg::ST_FIX:
            begin
                // wait here while the previous result is still held
                if (out_free)
                begin
                    cmd.write_out = 1'b1;
                    state_next    = iia_pkg::ST_IDLE;
                end
            end
            default: state_next = iia_pkg::ST_IDLE;
        endcase

        if (cmd.write_out)
            rsp_valid_next = 1'b1;
        else if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    assign rsp_valid = rsp_valid_reg;

    `IIA_ASSERT_NEXT(a_accept_runs, (req_valid && !req_stall), (state_reg == iia_pkg::ST_RUN), "accepted beat did not start the loop")
    `IIA_ASSERT_NOW(a_write_free, (!cmd.write_out || !rsp_valid_reg || !rsp_stall), "result register overwritten while stalled")
    `IIA_ASSERT_NEXT(a_last_step, (cmd.step && status.cnt_last), (state_reg == iia_pkg::ST_FIX), "loop ran past its last iteration")
    `IIA_ASSERT_NEXT(a_taken_clears, (rsp_valid_reg && !rsp_stall && !cmd.write_out), (!rsp_valid_reg), "result beat repeated")

endmodule

>>> test/tb_top.sv
// Self-checking testbench for iterative_integer_alu: directed corner cases and random traffic.
// Needs iia_pkg and the iterative_integer_alu RTL. A scoreboard class checks each response beat.
module tb_top;

    localparam int RANDOM_PER_PHASE = 550;
    localparam int HOLD_CYCLES      = 300;
    localparam int DRAIN_CYCLES     = 40;
    localparam int MAX_REPORTS      = 10;
    localparam int DW               = iia_pkg::DATA_WIDTH;

    class alu_result_board;
        iia_pkg::alu_rsp_t pending_results[$];
        int unsigned       mismatch_count;
        int unsigned       checked_count;

        function iia_pkg::alu_rsp_t compute_alu_result(iia_pkg::alu_req_t r);
            iia_pkg::alu_rsp_t o;
            longint            dividend;
            longint            divisor;
            o.div_by_zero = 1'b0;
            case (r.mode)
                iia_pkg::MODE_ADD: o.result = r.operand_a + r.operand_b;
                iia_pkg::MODE_SUB: o.result = r.operand_a - r.operand_b;
                iia_pkg::MODE_MUL: o.result = r.operand_a * r.operand_b;
                default:
                begin
                    if (r.operand_b == '0)
                    begin
                        o.result      = '0;
                        o.div_by_zero = 1'b1;
                    end
                    else if (r.operand_a == iia_pkg::INT_MIN && r.operand_b == '1)
                        o.result = iia_pkg::INT_MAX;  // saturate: no positive 2^31
                    else
                    begin
                        dividend = r.operand_a;
                        divisor  = r.operand_b;
                        o.result = DW'(dividend / divisor);
                    end
                end
            endcase
            return o;
        endfunction

        function void note_request(iia_pkg::alu_req_t r);
            pending_results.push_back(compute_alu_result(r));
        endfunction

        function void check_response(iia_pkg::alu_rsp_t got);
            iia_pkg::alu_rsp_t want;
            checked_count++;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected response beat: result=%0d div_by_zero=%0b",
                             got.result, got.div_by_zero);
                return;
            end
            want = pending_results.pop_front();
            if (got.result !== want.result || got.div_by_zero !== want.div_by_zero)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("mismatch: expected result=%0d dz=%0b, got result=%0d dz=%0b",
                             want.result, want.div_by_zero, got.result, got.div_by_zero);
            end
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    iia_pkg::alu_req_t req       = '0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    iia_pkg::alu_rsp_t rsp;

    int unsigned send_idle_pct = 32;
    int unsigned recv_idle_pct = 60;
    int unsigned hold_at;
    alu_result_board board;

    iterative_integer_alu dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [DW-1:0] random_operand();
        logic [DW-1:0] v;
        case ($urandom_range(9))
            6:       v = DW'($urandom_range(40)) - DW'(20);
            7:
            begin
                case ($urandom_range(3))
                    0:       v = iia_pkg::INT_MIN;
                    1:       v = iia_pkg::INT_MAX;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            8:       v = DW'(1) << $urandom_range(DW - 1);
            9:       v = $urandom >> $urandom_range(DW - 1);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Present one request beat and hold it until taken.
    task automatic drive_beat(input iia_pkg::alu_mode_t mode, input logic [DW-1:0] a,
                              input logic [DW-1:0] b);
        iia_pkg::alu_req_t r;
        r.mode      = mode;
        r.operand_a = a;
        r.operand_b = b;
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (req_stall);
        board.note_request(r);
    endtask

    task automatic sender_gap();
        int unsigned n;
        n = 0;
        if (send_idle_pct != 0)
        begin
            if ($urandom_range(99) < 3)
                n = $urandom_range(40, 1);
            else
            begin
                while ($urandom_range(99) < send_idle_pct)
                    n++;
            end
        end
        if (n > 0)
        begin
            req_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_random_items(input int count);
        for (int i = 0; i < count; i++)
        begin
            sender_gap();
            drive_beat(iia_pkg::alu_mode_t'($urandom_range(3)), random_operand(),
                       random_operand());
        end
    endtask

    task automatic send_directed();
        drive_beat(iia_pkg::MODE_ADD, iia_pkg::INT_MAX, 32'sd1);
        drive_beat(iia_pkg::MODE_ADD, '0, '0);
        drive_beat(iia_pkg::MODE_ADD, '1, '1);
        drive_beat(iia_pkg::MODE_SUB, iia_pkg::INT_MIN, 32'sd1);
        drive_beat(iia_pkg::MODE_SUB, '0, iia_pkg::INT_MIN);
        drive_beat(iia_pkg::MODE_SUB, iia_pkg::INT_MAX, '1);
        drive_beat(iia_pkg::MODE_MUL, iia_pkg::INT_MIN, '1);
        drive_beat(iia_pkg::MODE_MUL, iia_pkg::INT_MAX, iia_pkg::INT_MAX);
        drive_beat(iia_pkg::MODE_MUL, '0, iia_pkg::INT_MIN);
        drive_beat(iia_pkg::MODE_MUL, -32'sd7, 32'sd6);
        drive_beat(iia_pkg::MODE_DIV, 32'sd5, '0);
        drive_beat(iia_pkg::MODE_DIV, iia_pkg::INT_MIN, '0);
        drive_beat(iia_pkg::MODE_DIV, iia_pkg::INT_MIN, '1);
        drive_beat(iia_pkg::MODE_DIV, iia_pkg::INT_MIN, iia_pkg::INT_MIN);
        drive_beat(iia_pkg::MODE_DIV, iia_pkg::INT_MIN, 32'sd1);
        drive_beat(iia_pkg::MODE_DIV, iia_pkg::INT_MIN, 32'sd2);
        drive_beat(iia_pkg::MODE_DIV, iia_pkg::INT_MIN, iia_pkg::INT_MAX);
        drive_beat(iia_pkg::MODE_DIV, iia_pkg::INT_MAX, '1);
        drive_beat(iia_pkg::MODE_DIV, iia_pkg::INT_MAX, iia_pkg::INT_MAX);
        drive_beat(iia_pkg::MODE_DIV, 32'sd1, iia_pkg::INT_MIN);
        drive_beat(iia_pkg::MODE_DIV, -32'sd7, 32'sd2);
        drive_beat(iia_pkg::MODE_DIV, 32'sd7, -32'sd2);
        drive_beat(iia_pkg::MODE_DIV, -32'sd7, -32'sd2);
        drive_beat(iia_pkg::MODE_DIV, '0, 32'sd5);
        drive_beat(iia_pkg::MODE_DIV, 32'sd5, 32'sd7);
    endtask

    // Response side: check accepted beats, stall at random, one long hold-off in the last phase.
    initial
    begin
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
                board.check_response(rsp);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (!hold_done && hold_at != 0 && board.checked_count >= hold_at)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial
    begin
        board   = new();
        hold_at = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();
        send_random_items(RANDOM_PER_PHASE);

        send_idle_pct = 60;
        recv_idle_pct = 32;
        send_random_items(RANDOM_PER_PHASE);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_at       = board.checked_count + 20;
        send_random_items(RANDOM_PER_PHASE);

        req_valid <= 1'b0;
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.mismatch_count == 0 && board.pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/iia_pkg.sv
hw/rtl/iia_datapath.sv
hw/rtl/iia_controller.sv
hw/rtl/iterative_integer_alu.sv
test/tb_top.sv
